>>> rtl/mexp_pkg.sv
package mexp_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

>>> rtl/modular_exponentiation_top.sv
// Computes base^exponent mod modulus with right-to-left square-and-multiply.
// The exponent sits in a row of one-bit cells that shifts toward cell 0 after
// every exponent step; all products go through one shared shift-add modular
// multiplier that handles one multiplier bit per cycle. An item takes one
// reduction of the base plus, for each of the DATA_WIDTH exponent bits, a
// squaring and, when the bit is set, a multiply. One request is worked at a
// time; the finished result waits in the output register. A zero exponent
// gives 1, and a zero modulus makes the arithmetic wrap at DATA_WIDTH bits.
module modular_exponentiation_top #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]          i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [DATA_WIDTH-1:0]          i_base_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [DATA_WIDTH-1:0]          o_power_result
);
    import mexp_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int SW = $clog2(DW);

    typedef enum logic [2:0] {
        S_IDLE, S_RED, S_BIT, S_MUL, S_SQR, S_DONE
    } t_state;

    t_state        r_state;
    logic [DW-1:0] r_exp, r_mod, r_p, r_acc, r_out;
    logic [SW-1:0] r_step;
    logic          r_out_valid;

    logic          mm_start;
    logic [DW-1:0] mm_a, mm_b, mm_res;
    t_mm_status    mm_st;
    logic [DW-1:0] cell_bit;
    logic          cell_load, cell_shift, accept;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_mod <= DW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXPONENT: r_exp <= i_cfg_data;
                REG_MODULUS:  r_mod <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_p;
        mm_b     = r_p;
        case (r_state)
            S_IDLE: begin
                mm_start = accept;
                mm_a     = DW'(1);
                mm_b     = i_base_value;
            end
            S_BIT: begin
                mm_start = 1'b1;
                if (cell_bit[0]) begin
                    mm_a = r_acc;
                end
            end
            S_MUL: begin
                mm_start = mm_st.done;
            end
            default: ;
        endcase
    end

    assign cell_load  = accept;
    assign cell_shift = (r_state == S_SQR) && mm_st.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_acc   <= DW'(1);
                        r_step  <= '0;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (mm_st.done) begin
                        r_p     <= mm_res;
                        r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    r_state <= cell_bit[0] ? S_MUL : S_SQR;
                end
                S_MUL: begin
                    if (mm_st.done) begin
                        r_acc   <= mm_res;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (mm_st.done) begin
                        r_p    <= mm_res;
                        r_step <= r_step + 1'b1;
                        r_state <= (r_step == SW'(DW - 1)) ? S_DONE : S_BIT;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_cell
        logic next_bit;
        if (k == DW - 1) begin : g_last
            assign next_bit = 1'b0;
        end else begin : g_mid
            assign next_bit = cell_bit[k+1];
        end
        mexp_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (cell_load),
            .i_load_bit (r_exp[k]),
            .i_shift    (cell_shift),
            .i_next_bit (next_bit),
            .o_bit      (cell_bit[k])
        );
    end

    mexp_mulmod #(.DW(DW)) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_m      (r_mod),
        .o_result (mm_res),
        .o_status (mm_st)
    );

    assign o_valid        = r_out_valid;
    assign o_power_result = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_st.done |-> (r_state == S_RED || r_state == S_MUL || r_state == S_SQR))
        else $error("product finished with no step waiting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !mm_st.busy)
        else $error("multiplier busy outside a request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) mm_st.busy |-> !mm_start)
        else $error("multiplier restarted while busy");
endmodule

>>> rtl/mexp_cell.sv
module mexp_cell (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_load_bit,
    input  logic i_shift,
    input  logic i_next_bit,
    output logic o_bit
);
    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_load_bit;
        end else if (i_shift) begin
            r_bit <= i_next_bit;
        end
    end

    assign o_bit = r_bit;
endmodule

>>> rtl/mexp_mulmod.sv
module mexp_mulmod #(
    parameter int DW = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_a,
    input  logic [DW-1:0]            i_b,
    input  logic [DW-1:0]            i_m,
    output logic [DW-1:0]            o_result,
    output mexp_pkg::t_mm_status     o_status
);
    import mexp_pkg::*;

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic [DW-1:0] r_acc, r_a, r_b, r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   t_dbl, t_sum;
    logic [DW-1:0] n_acc, t_red, t_x;
    logic          m_zero;

    // one shift-add step: r = 2r mod m, then r = r + (bit ? a : 0) mod m
    always_comb begin
        m_zero = (r_m == '0);
        t_dbl  = {r_acc, 1'b0};
        if (!m_zero && t_dbl >= {1'b0, r_m}) begin
            t_dbl = t_dbl - {1'b0, r_m};
        end
        t_red = t_dbl[DW-1:0];
        t_x   = r_b[DW-1] ? r_a : '0;
        t_sum = {1'b0, t_red} + {1'b0, t_x};
        if (!m_zero && t_sum >= {1'b0, r_m}) begin
            t_sum = t_sum - {1'b0, r_m};
        end
        n_acc = t_sum[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
                r_acc  <= '0;
                // modulus one: every product is zero
                r_a    <= (i_m == DW'(1)) ? '0 : i_a;
                r_b    <= i_b;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= {r_b[DW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_result      = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("mulmod done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> r_done)
        else $error("mulmod missed done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy)
        else $error("mulmod did not start");
endmodule
